// ===== rtl/sfcd_pkg.sv =====
// shared types and constants for the serial frame check and dispatch block
package sfcd_pkg;

    // number of node slots held in the configuration registers
    localparam int NODE_SLOTS = 4;
    localparam int SLOT_W     = 2;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_MASK = 3'd4;

    // frame layout
    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'hD5;
    localparam logic [7:0] MIN_LEN  = 8'd4;
    localparam logic [7:0] POS_IDLE = 8'd0;
    localparam logic [7:0] POS_LEN  = 8'd1;
    localparam logic [7:0] POS_NODE = 8'd2;
    localparam logic [7:0] POS_CMD  = 8'd3;

    // command codes
    localparam logic [7:0] CMD_BOOT      = 8'd0;
    localparam logic [7:0] CMD_SDO_READ  = 8'd1;
    localparam logic [7:0] CMD_SDO_WRITE = 8'd2;
    localparam logic [7:0] CMD_ERROR     = 8'd3;
    localparam logic [7:0] CMD_CONTROL   = 8'd4;
    localparam logic [7:0] CMD_STATUS    = 8'd5;
    localparam logic [7:0] CMD_EMERGENCY = 8'd7;

    // result classes
    typedef enum logic [2:0] {
        KIND_REJECTED  = 3'd0,
        KIND_SYSTEM    = 3'd1,
        KIND_SDO_RESP  = 3'd2,
        KIND_IGNORED   = 3'd3,
        KIND_MALFORMED = 3'd4
    } frame_kind_t;

    // queue between parser and dispatcher
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // one closed frame as seen by the parser
    typedef struct packed {
        logic       short_len;
        logic       crc_ok;
        logic [7:0] node_number;
        logic [7:0] command_code;
        logic [7:0] frame_length;
    } frame_rec_t;

endpackage

// ===== rtl/serial_frame_check_dispatch.sv =====
// top level of the serial frame check and dispatch block
//
// Input channel s_*: one received frame byte per item in s_tdata, with
// s_tuser set on the start byte of a new frame. A parser follows the
// frame position, captures length, node and command bytes and runs the
// reflected crc-8; when the crc byte (or a too-short length byte)
// arrives it drops one record into a four-entry queue.
// Result channel m_*: one item per closed frame, the class in m_tuser
// and the slot match, crc status and header bytes in m_tdata.
// Throughput is one byte per cycle while s_tready is high. A result
// passes the queue and then the output register: the parser writes
// the record into the queue at the accepting edge, and the dispatcher
// matches the slot, classifies and loads the output register when it
// is free. If the receiver stalls, results wait in the output register
// and the queue; s_tready drops only while the queue holds four records.
// Configuration (node ids, slot mask) is written through cfg_wr_en at
// any edge and should change only while no frame is in flight.
// Reset (aresetn low, synchronous) closes any open frame, empties the
// queue, clears m_tvalid and sets all configuration registers to zero.
module serial_frame_check_dispatch (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [sfcd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sfcd_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,  // rx_byte
    input  logic                            s_tuser,  // frame_start
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // node_known, node_slot[1:0], crc_ok, node_number[7:0],
    // command_code[7:0], frame_length[7:0], zero fill
    output logic [31:0]                     m_tdata,
    output logic [2:0]                      m_tuser   // frame_kind
);
    import sfcd_pkg::*;

    frame_rec_t push_rec, head_rec;
    logic       push, pop, q_empty, q_full, byte_valid;

    assign s_tready   = !q_full;
    assign byte_valid = s_tvalid && s_tready;

    // frame parser
    sfcd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_valid  (byte_valid),
        .rx_byte     (s_tdata),
        .frame_start (s_tuser),
        .rec_push    (push),
        .rec_data    (push_rec)
    );

    // record queue
    sfcd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_rec),
        .pop       (pop),
        .head_data (head_rec),
        .empty     (q_empty),
        .full      (q_full)
    );

    // dispatcher and output register
    sfcd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .rec_data  (head_rec),
        .rec_empty (q_empty),
        .rec_pop   (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ===== rtl/sfcd_front.sv =====
// byte parser: tracks frame position, runs the crc and emits one record per closed frame
module sfcd_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              byte_valid,
    input  logic [7:0]        rx_byte,
    input  logic              frame_start,
    output logic              rec_push,
    output sfcd_pkg::frame_rec_t rec_data
);
    import sfcd_pkg::*;

    logic [7:0] pos_reg,  pos_next;
    logic [7:0] crc_reg,  crc_next;
    logic [7:0] len_reg,  len_next;
    logic [7:0] node_reg, node_next;
    logic [7:0] cmd_reg,  cmd_next;

    logic [7:0] len_v, node_v, cmd_v;
    logic [7:0] crc_upd;

    // reflected crc-8 over one byte, lsb first
    function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // header bytes as they stand after this item
    always_comb begin
        len_v   = (pos_reg == POS_LEN)  ? rx_byte : len_reg;
        node_v  = (pos_reg == POS_NODE) ? rx_byte : node_reg;
        cmd_v   = (pos_reg == POS_CMD)  ? rx_byte : cmd_reg;
        crc_upd = crc_step(crc_reg, rx_byte);
    end

    // frame tracking
    always_comb begin
        pos_next  = pos_reg;
        crc_next  = crc_reg;
        len_next  = len_reg;
        node_next = node_reg;
        cmd_next  = cmd_reg;
        rec_push  = 1'b0;
        rec_data  = '0;
        if (byte_valid) begin
            if (frame_start) begin
                pos_next  = POS_LEN;
                crc_next  = CRC_INIT;
                len_next  = '0;
                node_next = '0;
                cmd_next  = '0;
            end else if (pos_reg != POS_IDLE) begin
                len_next  = len_v;
                node_next = node_v;
                cmd_next  = cmd_v;
                if (pos_reg == POS_LEN && rx_byte < MIN_LEN) begin
                    // length too short: close at once
                    rec_push               = 1'b1;
                    rec_data.short_len     = 1'b1;
                    rec_data.frame_length  = rx_byte;
                    pos_next               = POS_IDLE;
                    crc_next               = CRC_INIT;
                end else if (pos_reg < len_v) begin
                    crc_next = crc_upd;
                    pos_next = pos_reg + 8'd1;
                end else begin
                    // crc byte closes the frame
                    rec_push              = 1'b1;
                    rec_data.crc_ok       = (rx_byte == crc_reg);
                    rec_data.node_number  = node_v;
                    rec_data.command_code = cmd_v;
                    rec_data.frame_length = len_v;
                    pos_next              = POS_IDLE;
                    crc_next              = CRC_INIT;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= POS_IDLE;
            crc_reg  <= CRC_INIT;
            len_reg  <= '0;
            node_reg <= '0;
            cmd_reg  <= '0;
        end else begin
            pos_reg  <= pos_next;
            crc_reg  <= crc_next;
            len_reg  <= len_next;
            node_reg <= node_next;
            cmd_reg  <= cmd_next;
        end
    end

endmodule

// ===== rtl/sfcd_queue.sv =====
// short fifo of closed-frame records between parser and dispatcher
module sfcd_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  sfcd_pkg::frame_rec_t push_data,
    input  logic              pop,
    output sfcd_pkg::frame_rec_t head_data,
    output logic              empty,
    output logic              full
);
    import sfcd_pkg::*;

    frame_rec_t         mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  cnt_reg,    cnt_next;
    logic               do_push, do_pop;

    assign empty     = (cnt_reg == '0);
    assign full      = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_data = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;

    // pointer and fill count
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/sfcd_back.sv =====
// dispatcher: node slot match, classification and the output register
module sfcd_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [sfcd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sfcd_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  sfcd_pkg::frame_rec_t          rec_data,
    input  logic                          rec_empty,
    output logic                          rec_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [31:0]                   m_tdata,
    output logic [2:0]                    m_tuser
);
    import sfcd_pkg::*;

    logic [7:0]            node_id_reg [NODE_SLOTS];
    logic [NODE_SLOTS-1:0] slot_mask_reg;

    logic                  valid_reg, valid_next;
    frame_kind_t           kind_reg,  kind_next;
    logic                  known_reg, known_next;
    logic [SLOT_W-1:0]     slot_reg,  slot_next;
    logic                  ok_reg,    ok_next;
    logic [7:0]            node_reg,  node_next;
    logic [7:0]            cmd_reg,   cmd_next;
    logic [7:0]            len_reg,   len_next;

    logic                  hit;
    logic [SLOT_W-1:0]     hit_slot;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NODE_SLOTS; i++) begin
                node_id_reg[i] <= '0;
            end
            slot_mask_reg <= '0;
        end else if (cfg_wr_en) begin
            if (cfg_index == CFG_SLOT_MASK) begin
                slot_mask_reg <= cfg_wdata[NODE_SLOTS-1:0];
            end
            for (int i = 0; i < NODE_SLOTS; i++) begin
                if (cfg_index == CFG_NODE_ID0 + CFG_IDX_W'(i)) begin
                    node_id_reg[i] <= cfg_wdata;
                end
            end
        end
    end

    // highest enabled slot whose id matches
    always_comb begin
        hit      = 1'b0;
        hit_slot = '0;
        for (int i = 0; i < NODE_SLOTS; i++) begin
            if (slot_mask_reg[i] && node_id_reg[i] == rec_data.node_number) begin
                hit      = 1'b1;
                hit_slot = SLOT_W'(i);
            end
        end
    end

    assign rec_pop = !rec_empty && (!valid_reg || m_tready);

    // classification and output register load
    always_comb begin
        valid_next = valid_reg;
        kind_next  = kind_reg;
        known_next = known_reg;
        slot_next  = slot_reg;
        ok_next    = ok_reg;
        node_next  = node_reg;
        cmd_next   = cmd_reg;
        len_next   = len_reg;
        if (m_tready) begin
            valid_next = 1'b0;
        end
        if (rec_pop) begin
            valid_next = 1'b1;
            len_next   = rec_data.frame_length;
            if (rec_data.short_len) begin
                kind_next  = KIND_MALFORMED;
                known_next = 1'b0;
                slot_next  = '0;
                ok_next    = 1'b0;
                node_next  = '0;
                cmd_next   = '0;
            end else begin
                known_next = hit;
                slot_next  = hit_slot;
                ok_next    = rec_data.crc_ok;
                node_next  = rec_data.node_number;
                cmd_next   = rec_data.command_code;
                if (!hit || !rec_data.crc_ok) begin
                    kind_next = KIND_REJECTED;
                end else if (rec_data.command_code inside
                             {CMD_BOOT, CMD_CONTROL, CMD_STATUS, CMD_EMERGENCY}) begin
                    kind_next = KIND_SYSTEM;
                end else if (rec_data.command_code inside
                             {CMD_SDO_READ, CMD_SDO_WRITE, CMD_ERROR}) begin
                    kind_next = KIND_SDO_RESP;
                end else begin
                    kind_next = KIND_IGNORED;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg  <= kind_next;
        known_reg <= known_next;
        slot_reg  <= slot_next;
        ok_reg    <= ok_next;
        node_reg  <= node_next;
        cmd_reg   <= cmd_next;
        len_reg   <= len_next;
    end

    // result item
    assign m_tvalid = valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = {4'b0, len_reg, cmd_reg, node_reg, ok_reg, slot_reg, known_reg};

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for the serial frame check and dispatch block
module testbench;
    import sfcd_pkg::*;

    // expected content of one result item
    typedef struct {
        frame_kind_t kind;
        logic        known;
        logic [1:0]  slot;
        logic        ok;
        logic [7:0]  node;
        logic [7:0]  cmd;
        logic [7:0]  len;
    } frame_result_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = 8'h00;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [31:0]           m_tdata;
    logic [2:0]            m_tuser;

    // expected results in arrival order
    frame_result_t pending_results[$];
    frame_result_t head;
    int            errors        = 0;
    int            live_items    = 0;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;

    // predictor copy of configuration and parser state
    logic [7:0] slot_id [NODE_SLOTS];
    logic [3:0] slot_mask;
    logic [7:0] frame_pos;
    logic [7:0] frame_crc;
    logic [7:0] frame_len;
    logic [7:0] frame_node;
    logic [7:0] frame_cmd;

    serial_frame_check_dispatch dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #1 aclk = ~aclk;

    // receiver stalls at random
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // reflected crc-8, lsb first
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[0]) c = (c >> 1) ^ CRC_POLY;
            else      c = c >> 1;
        end
        return c;
    endfunction

    // frame parser and dispatcher prediction for one accepted item
    task automatic predict_frame_byte(input logic [7:0] b, input logic st);
        frame_result_t r;
        if (st) begin
            frame_pos  = POS_LEN;
            frame_crc  = CRC_INIT;
            frame_len  = 8'h00;
            frame_node = 8'h00;
            frame_cmd  = 8'h00;
            live_items++;
            return;
        end
        if (frame_pos == POS_IDLE) return;
        live_items++;
        if (frame_pos == POS_LEN) begin
            frame_len = b;
            // too-short length closes the frame at once
            if (b < MIN_LEN) begin
                r.kind  = KIND_MALFORMED;
                r.known = 1'b0;
                r.slot  = 2'd0;
                r.ok    = 1'b0;
                r.node  = 8'h00;
                r.cmd   = 8'h00;
                r.len   = b;
                pending_results.push_back(r);
                frame_pos = POS_IDLE;
                frame_crc = CRC_INIT;
                return;
            end
        end else if (frame_pos == POS_NODE) begin
            frame_node = b;
        end else if (frame_pos == POS_CMD) begin
            frame_cmd = b;
        end
        if (frame_pos < frame_len) begin
            frame_crc = crc8_update(frame_crc, b);
            frame_pos = frame_pos + 8'd1;
            return;
        end
        // crc byte: highest enabled matching slot wins
        r.ok    = (b == frame_crc);
        r.known = 1'b0;
        r.slot  = 2'd0;
        for (int i = 0; i < NODE_SLOTS; i++) begin
            if (slot_mask[i] && slot_id[i] == frame_node) begin
                r.known = 1'b1;
                r.slot  = i[1:0];
            end
        end
        if (!r.known || !r.ok) begin
            r.kind = KIND_REJECTED;
        end else begin
            case (frame_cmd)
                CMD_BOOT, CMD_CONTROL, CMD_STATUS, CMD_EMERGENCY: r.kind = KIND_SYSTEM;
                CMD_SDO_READ, CMD_SDO_WRITE, CMD_ERROR:           r.kind = KIND_SDO_RESP;
                default:                                          r.kind = KIND_IGNORED;
            endcase
        end
        r.node = frame_node;
        r.cmd  = frame_cmd;
        r.len  = frame_len;
        pending_results.push_back(r);
        frame_pos = POS_IDLE;
        frame_crc = CRC_INIT;
    endtask

    // check each result item against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result item: kind %0d data %h", m_tuser, m_tdata);
                errors++;
            end else begin
                head = pending_results.pop_front();
                if (m_tuser !== head.kind) begin
                    $error("frame_kind: expected %0d, got %0d", head.kind, m_tuser);
                    errors++;
                end
                if (m_tdata[0] !== head.known) begin
                    $error("node_known: expected %0d, got %0d", head.known, m_tdata[0]);
                    errors++;
                end
                if (m_tdata[2:1] !== head.slot) begin
                    $error("node_slot: expected %0d, got %0d", head.slot, m_tdata[2:1]);
                    errors++;
                end
                if (m_tdata[3] !== head.ok) begin
                    $error("crc_ok: expected %0d, got %0d", head.ok, m_tdata[3]);
                    errors++;
                end
                if (m_tdata[11:4] !== head.node) begin
                    $error("node_number: expected %h, got %h", head.node, m_tdata[11:4]);
                    errors++;
                end
                if (m_tdata[19:12] !== head.cmd) begin
                    $error("command_code: expected %h, got %h", head.cmd, m_tdata[19:12]);
                    errors++;
                end
                if (m_tdata[27:20] !== head.len) begin
                    $error("frame_length: expected %h, got %h", head.len, m_tdata[27:20]);
                    errors++;
                end
                if (m_tdata[31:28] !== 4'h0) begin
                    $error("zero fill: expected 0, got %h", m_tdata[31:28]);
                    errors++;
                end
            end
        end
    end

    // send one byte item, with random sender gaps
    task automatic send_byte(input logic [7:0] b, input logic st);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= st;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_frame_byte(b, st);
    endtask

    // send a whole frame of length len, crc optionally corrupted
    task automatic send_frame(input logic [7:0] node, input logic [7:0] cmd,
                              input logic [7:0] len, input logic bad_crc);
        logic [7:0] c;
        logic [7:0] b;
        c = CRC_INIT;
        send_byte(8'($urandom_range(255)), 1'b1);
        send_byte(len, 1'b0);
        c = crc8_update(c, len);
        send_byte(node, 1'b0);
        c = crc8_update(c, node);
        send_byte(cmd, 1'b0);
        c = crc8_update(c, cmd);
        for (int p = 4; p < len; p++) begin
            b = 8'($urandom_range(255));
            send_byte(b, 1'b0);
            c = crc8_update(c, b);
        end
        if (bad_crc) c = c ^ 8'($urandom_range(255, 1));
        send_byte(c, 1'b0);
    endtask

    // drain all expected results, then let the pipeline settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // write all node ids and the slot mask while idle
    task automatic set_config(input logic [31:0] ids, input logic [3:0] mask);
        logic [CFG_IDX_W-1:0] idx;
        wait_idle();
        for (int i = 0; i < NODE_SLOTS; i++) begin
            idx = CFG_NODE_ID0 + CFG_IDX_W'(i);
            cfg_wr_en <= 1'b1;
            cfg_index <= idx;
            cfg_wdata <= ids[8*i +: 8];
            @(posedge aclk);
            slot_id[i] = ids[8*i +: 8];
        end
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_SLOT_MASK;
        cfg_wdata <= {4'h0, mask};
        @(posedge aclk);
        slot_mask = mask;
        cfg_wr_en <= 1'b0;
    endtask

    // random ids with zeros, all-ones and duplicates mixed in
    task automatic random_config();
        logic [31:0] ids;
        logic [3:0]  mask;
        int          pick;
        for (int i = 0; i < NODE_SLOTS; i++) begin
            pick = $urandom_range(99);
            if (pick < 15)      ids[8*i +: 8] = 8'h00;
            else if (pick < 25) ids[8*i +: 8] = 8'hFF;
            else if (pick < 45 && i > 0)
                ids[8*i +: 8] = ids[8*$urandom_range(i-1) +: 8];
            else                ids[8*i +: 8] = 8'($urandom_range(255));
        end
        pick = $urandom_range(99);
        if (pick < 15)      mask = 4'hF;
        else if (pick < 22) mask = 4'h0;
        else                mask = 4'($urandom_range(15));
        set_config(ids, mask);
    endtask

    // bytes with no open frame are dropped
    task automatic test_idle_bytes();
        send_byte(8'hA5, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
    endtask

    // length below the minimum closes the frame at once
    task automatic test_short_length();
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(MIN_LEN - 8'd1, 1'b0);
        // byte after the short frame has no open frame
        send_byte(8'h5A, 1'b0);
    endtask

    // slot matching, mask, duplicates, bad crc, longest frame
    task automatic test_slot_match();
        // reset config: ids match node 0 but no slot is enabled
        send_frame(8'h00, CMD_BOOT, MIN_LEN, 1'b0);
        set_config({8'h42, 8'h42, 8'hFF, 8'h00}, 4'hF);
        send_frame(8'h42, CMD_SDO_READ, MIN_LEN, 1'b0);
        send_frame(8'hFF, CMD_STATUS, 8'hFF, 1'b0);
        send_frame(8'h00, CMD_CONTROL, MIN_LEN, 1'b1);
        send_frame(8'h13, CMD_BOOT, MIN_LEN, 1'b0);
        set_config({8'h42, 8'h42, 8'hFF, 8'h00}, 4'h5);
        send_frame(8'h42, CMD_SDO_WRITE, 8'd5, 1'b0);
    endtask

    // every command class
    task automatic test_commands();
        logic [7:0] codes [8];
        codes = '{CMD_BOOT, CMD_SDO_READ, CMD_SDO_WRITE, CMD_ERROR,
                  CMD_CONTROL, CMD_STATUS, 8'd6, CMD_EMERGENCY};
        for (int i = 0; i < 8; i++) send_frame(8'h00, codes[i], MIN_LEN, 1'b0);
        send_frame(8'hFF, 8'hFF, MIN_LEN, 1'b0);
    endtask

    // start byte inside an open frame drops it
    task automatic test_restart();
        send_byte(8'h11, 1'b1);
        send_byte(8'd6, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h22, 1'b1);
        send_frame(8'hFF, CMD_ERROR, MIN_LEN, 1'b0);
    endtask

    // mostly well-formed frames, some broken ones and noise
    task automatic test_random_traffic(input int n_items);
        int         target;
        int         next_cfg;
        int         pick;
        int         cut;
        logic [7:0] node;
        logic [7:0] cmd;
        logic [7:0] len;
        target   = live_items + n_items;
        next_cfg = live_items + $urandom_range(160, 60);
        random_config();
        while (live_items < target) begin
            if (live_items >= next_cfg) begin
                random_config();
                next_cfg = live_items + $urandom_range(160, 60);
            end
            node = ($urandom_range(99) < 65) ? slot_id[$urandom_range(NODE_SLOTS-1)]
                                              : 8'($urandom_range(255));
            cmd  = ($urandom_range(99) < 65) ? 8'($urandom_range(7)) : 8'($urandom_range(255));
            pick = $urandom_range(99);
            if (pick < 85)      len = 8'($urandom_range(10, MIN_LEN));
            else if (pick < 98) len = 8'($urandom_range(40, 11));
            else                len = 8'($urandom_range(255, 41));
            pick = $urandom_range(99);
            if (pick < 72) begin
                send_frame(node, cmd, len, $urandom_range(99) < 15);
            end else if (pick < 80) begin
                send_byte(8'($urandom_range(255)), 1'b1);
                send_byte(8'($urandom_range(MIN_LEN - 1)), 1'b0);
            end else if (pick < 90) begin
                // broken frame cut short by the next start byte
                cut = $urandom_range(4, 1);
                send_byte(8'($urandom_range(255)), 1'b1);
                for (int k = 0; k < cut; k++) begin
                    send_byte((k == 0) ? len : 8'($urandom_range(255)), 1'b0);
                end
            end else begin
                for (int k = 0; k < $urandom_range(4, 1); k++) begin
                    send_byte(8'($urandom_range(255)), $urandom_range(99) < 20);
                end
            end
        end
    endtask

    // run control
    initial begin
        for (int i = 0; i < NODE_SLOTS; i++) slot_id[i] = 8'h00;
        slot_mask  = 4'h0;
        frame_pos  = POS_IDLE;
        frame_crc  = CRC_INIT;
        frame_len  = 8'h00;
        frame_node = 8'h00;
        frame_cmd  = 8'h00;
        send_idle_pct = 6;
        recv_idle_pct = 69;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_idle_bytes();
        test_short_length();
        test_slot_match();
        test_commands();
        test_restart();

        test_random_traffic(430);
        wait_idle();
        send_idle_pct = 69;
        recv_idle_pct = 6;
        test_random_traffic(430);
        wait_idle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(430);

        // drain with a bound, then settle
        s_tvalid <= 1'b0;
        for (int w = 0; w < 20000 && pending_results.size() != 0; w++) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (pending_results.size() != 0) begin
            $error("%0d expected result items never arrived", pending_results.size());
            errors++;
        end
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // hard stop if the run hangs
    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
